@@ hw/rtl/i2csra_pkg.sv @@
`default_nettype none

package i2csra_pkg;

  // Register file geometry and the writable window.
  localparam int unsigned REG_DEPTH = 64;
  localparam int unsigned REG_AW = $clog2(REG_DEPTH);
  localparam logic [7:0] LAST_REG = 8'd63;
  localparam logic [7:0] FIRST_WRITABLE = 8'd16;
  localparam logic [3:0] ERR_MASK = 4'hF;

  // Bus event codes.
  typedef logic [1:0] action_t;
  localparam action_t ACT_NONE = 2'd0;
  localparam action_t ACT_MATCH = 2'd1;
  localparam action_t ACT_WRITE = 2'd2;
  localparam action_t ACT_READ = 2'd3;

  // One bus byte event.
  typedef struct packed {
    action_t    action;
    logic [7:0] data_byte;
    logic       stop_seen;
    logic       nack_seen;
    logic [3:0] bus_errors;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [7:0] read_byte;
    logic       read_valid;
    logic       txn_active;
    logic [3:0] error_bits;
    logic [7:0] last_register;
  } out_item_t;

endpackage

`default_nettype wire

@@ hw/rtl/i2csra_in_if.sv @@
`default_nettype none

interface i2csra_in_if;
  logic                 valid;
  logic                 ready;
  i2csra_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2csra_out_if.sv @@
`default_nettype none

interface i2csra_out_if;
  logic                  valid;
  logic                  ready;
  i2csra_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/i2csra_ram.sv @@
`default_nettype none

module i2csra_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/i2c_slave_register_access.sv @@
`default_nettype none

// Byte-level register access for an I2C slave.
// in_ch carries one bus byte event per beat (address match, master write,
// master read request, plus stop, NACK and bus error flags). out_ch returns
// exactly one result beat per event: the read byte on a read request, the
// transaction status, the event's error bits and the last requested register.
// A first write after an address match loads the register pointer; later
// writes land in the 64-byte register file, kept inside the writable window.
// Throughput is one event per cycle unless the receiver stalls: pointer and flag
// updates are a few gates, and the register file is a single-port-write,
// registered-read RAM accessed in the accept cycle. The RAM read is registered
// at the accepting edge together with the middle stage, and the result beat
// then passes through the output register that drives out_ch.valid.
// Reset clears the pointer, the flags and the requested register, and marks
// every register byte as unwritten; unwritten bytes read as zero, so no
// clearing pass is needed and events are taken right after reset.
// When the receiver stalls, the output register holds its beat, the middle
// stage fills, and in_ch.ready drops until the output moves again.
module i2c_slave_register_access (
  input  wire logic  clk,
  input  wire logic  rst_n,
  i2csra_in_if.sink  in_ch,
  i2csra_out_if.source out_ch
);

  import i2csra_pkg::*;

  typedef struct packed {
    logic       rd_live;
    logic       read_valid;
    logic       txn_active;
    logic [3:0] error_bits;
    logic [7:0] last_register;
  } mid_t;

  logic [7:0] ptr_r, ptr_nxt;
  logic       fbp_r, fbp_nxt;
  logic       open_r, open_nxt;
  logic [7:0] req_r, req_nxt;
  logic [REG_DEPTH-1:0] ent_vld_r;

  logic              wr_en, rd_en;
  logic [7:0]        wr_ptr, rd_ptr;
  logic [REG_AW-1:0] wr_addr, rd_addr;
  logic [7:0]        ram_dout;
  logic [3:0]        errs;
  logic              closing;
  logic              in_acc, mid_move;

  logic  mid_vld_r;
  mid_t  mid_r, mid_nxt;
  logic      out_vld_r;
  out_item_t out_r;

  // Handshake: the middle stage drains into the output register.
  assign mid_move = mid_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !mid_vld_r || mid_move;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign errs = in_ch.data.bus_errors & ERR_MASK;
  assign closing = in_ch.data.stop_seen || in_ch.data.nack_seen || (errs != 4'd0);

  // Window handling of the pointer for data writes and reads.
  assign wr_ptr = ((ptr_r > LAST_REG) || (ptr_r < FIRST_WRITABLE)) ? FIRST_WRITABLE : ptr_r;
  assign rd_ptr = (ptr_r > LAST_REG) ? 8'd0 : ptr_r;
  assign wr_addr = wr_ptr[REG_AW-1:0];
  assign rd_addr = rd_ptr[REG_AW-1:0];

  // Next state of the pointer, flags and requested register.
  always_comb begin
    ptr_nxt = ptr_r;
    fbp_nxt = fbp_r;
    open_nxt = open_r;
    req_nxt = req_r;
    wr_en = 1'b0;
    rd_en = 1'b0;
    unique case (in_ch.data.action)
      ACT_MATCH: begin
        fbp_nxt = 1'b1;
        open_nxt = 1'b1;
      end
      ACT_WRITE: begin
        if (fbp_r) begin
          req_nxt = in_ch.data.data_byte;
          ptr_nxt = in_ch.data.data_byte;
          fbp_nxt = 1'b0;
        end else begin
          wr_en = in_acc && (32'(wr_ptr) < REG_DEPTH);
          ptr_nxt = wr_ptr + 8'd1;
        end
      end
      ACT_READ: begin
        rd_en = in_acc;
        ptr_nxt = rd_ptr + 8'd1;
      end
      default: begin
      end
    endcase
    if (closing) begin
      fbp_nxt = 1'b0;
      open_nxt = 1'b0;
    end
  end

  // Fields of the result, except the RAM byte, which comes from the registered RAM read.
  always_comb begin
    mid_nxt.read_valid = (in_ch.data.action == ACT_READ);
    mid_nxt.rd_live = (in_ch.data.action == ACT_READ) && (32'(rd_ptr) < REG_DEPTH)
                      && ent_vld_r[rd_addr];
    mid_nxt.txn_active = open_nxt;
    mid_nxt.error_bits = errs;
    mid_nxt.last_register = req_nxt;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= 8'd0;
      fbp_r <= 1'b0;
      open_r <= 1'b0;
      req_r <= 8'd0;
      ent_vld_r <= '0;
      mid_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_acc) begin
        ptr_r <= ptr_nxt;
        fbp_r <= fbp_nxt;
        open_r <= open_nxt;
        req_r <= req_nxt;
      end
      if (wr_en) begin
        ent_vld_r[wr_addr] <= 1'b1;
      end
      if (in_acc) begin
        mid_vld_r <= 1'b1;
      end else if (mid_move) begin
        mid_vld_r <= 1'b0;
      end
      if (mid_move) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload stages.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mid_r <= mid_nxt;
    end
    if (mid_move) begin
      out_r.read_byte <= mid_r.rd_live ? ram_dout : 8'd0;
      out_r.read_valid <= mid_r.read_valid;
      out_r.txn_active <= mid_r.txn_active;
      out_r.error_bits <= mid_r.error_bits;
      out_r.last_register <= mid_r.last_register;
    end
  end

  i2csra_ram #(
    .WIDTH (8),
    .DEPTH (REG_DEPTH)
  ) u_regfile (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (in_ch.data.data_byte),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (ram_dout)
  );

  assign out_ch.valid = out_vld_r;
  assign out_ch.data = out_r;

  // A pending first byte only exists inside an open transaction.
  a_fbp_open: assert property (@(posedge clk) disable iff (!rst_n)
    fbp_r |-> open_r)
    else $error("first byte pending outside a transaction");

  // Data writes stay inside the writable window.
  a_wr_window: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (wr_ptr >= FIRST_WRITABLE) && (wr_ptr <= LAST_REG))
    else $error("register write outside the writable window");

  // A non-read beat carries no read byte.
  a_rd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_r.read_valid) |-> (out_r.read_byte == 8'd0))
    else $error("read byte set on a non-read beat");

  // A blocked middle stage keeps its contents.
  a_mid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mid_vld_r && !mid_move) |=> (mid_vld_r && $stable(mid_r)))
    else $error("middle stage lost a beat while blocked");

  // An unclosed address match opens the transaction.
  a_match_open: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.data.action == ACT_MATCH) && !closing) |=> (open_r && fbp_r))
    else $error("address match did not open a transaction");

endmodule

`default_nettype wire
